// ===== hw/rtl/event_image_variance_core_macros.svh =====
// ----------------------------------------------------------------------------
// Event image variance core assertion macros
// Shared assertion forms for the checker of the event image block.
// ----------------------------------------------------------------------------
`ifndef EVENT_IMAGE_VARIANCE_CORE_MACROS_SVH
`define EVENT_IMAGE_VARIANCE_CORE_MACROS_SVH
// Same-cycle implication, checked out of reset.
`define EVAR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("event image variance check failed");
// Next-cycle implication, checked out of reset.
`define EVAR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("event image variance check failed");
`endif

// ===== hw/rtl/evar_pkg.sv =====
// ----------------------------------------------------------------------------
// Event image variance package
// Types and constants shared by the event image variance modules.
// ----------------------------------------------------------------------------
`default_nettype none
package evar_pkg;
	localparam int MAX_PIXELS = 1048576;
	localparam int PIXEL_BITS = 16;
	localparam int ADDR_BITS  = $clog2(MAX_PIXELS);
	localparam int CFG_BITS   = 13;
	localparam int NUM_W      = 96;
	localparam int DIV_W      = 100;
	localparam int REM_W      = 53;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0]  command;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic        polarity;
	} in_item_t;

	typedef struct packed {
		logic [47:0] variance_q16;
		logic [15:0] max_count;
		logic [31:0] event_total;
	} out_item_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] width;
		logic [CFG_BITS-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic [1:0]           op;
		logic [ADDR_BITS-1:0] idx;
		logic                 pol;
	} op_t;

	typedef struct packed {
		logic push;
		logic full;
	} front_ctl_t;

	typedef struct packed {
		logic init;
		logic pop;
	} back_ctl_t;
endpackage
`default_nettype wire

// ===== hw/rtl/evar_front.sv =====
// ----------------------------------------------------------------------------
// Event image variance front end
// Accepts items, drops events outside the image and computes pixel addresses.
// ----------------------------------------------------------------------------
`default_nettype none
module evar_front (
	input  wire  evar_pkg::in_item_t   in_item,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire  evar_pkg::cfg_t       cfg,
	input  wire                        init,
	input  wire                        full,
	output evar_pkg::front_ctl_t       ctl,
	output evar_pkg::op_t              op
);
	logic [25:0] addr_full;
	logic        hit;

	always_comb begin
		addr_full = 26'(in_item.pos_y) * 26'(cfg.width) + 26'(in_item.pos_x);
		hit = (13'(in_item.pos_x) < cfg.width) && (13'(in_item.pos_y) < cfg.height) &&
			(addr_full < 26'(evar_pkg::MAX_PIXELS));
		in_stall = full || init;
		op.op  = in_item.command;
		op.idx = addr_full[evar_pkg::ADDR_BITS-1:0];
		op.pol = in_item.polarity;
		ctl.full = full;
		ctl.push = in_valid && !in_stall && ((in_item.command == evar_pkg::CMD_CLEAR) ||
			(in_item.command == evar_pkg::CMD_FINISH) ||
			((in_item.command == evar_pkg::CMD_ADD) && hit));
	end
endmodule
`default_nettype wire

// ===== hw/rtl/evar_queue.sv =====
// ----------------------------------------------------------------------------
// Event image variance operation queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module evar_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire  evar_pkg::op_t push_op,
	input  wire                 pop,
	output evar_pkg::op_t       head,
	output logic                empty,
	output logic                full
);
	evar_pkg::op_t slot_q [2];
	logic          rd_q;
	logic          wr_q;
	logic [1:0]    cnt_q;

	assign head  = slot_q[rd_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_op;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/evar_back.sv =====
// ----------------------------------------------------------------------------
// Event image variance back end
// Pixel memory, running sums, serial multiplier and divider for the variance.
// ----------------------------------------------------------------------------
`default_nettype none
module evar_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire  evar_pkg::cfg_t cfg,
	input  wire  evar_pkg::op_t  head,
	input  wire                  empty,
	output evar_pkg::back_ctl_t  ctl,
	output logic                 out_valid,
	input  wire                  out_stall,
	output evar_pkg::out_item_t  out_item
);
	localparam logic [3:0] ST_INIT  = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_CLEAR = 4'd2;
	localparam logic [3:0] ST_READ  = 4'd3;
	localparam logic [3:0] ST_UPD   = 4'd4;
	localparam logic [3:0] ST_FN    = 4'd5;
	localparam logic [3:0] ST_FD    = 4'd6;
	localparam logic [3:0] ST_M1    = 4'd7;
	localparam logic [3:0] ST_M2    = 4'd8;
	localparam logic [3:0] ST_M3    = 4'd9;
	localparam logic [3:0] ST_DSET  = 4'd10;
	localparam logic [3:0] ST_DIV   = 4'd11;
	localparam logic [3:0] ST_OUT   = 4'd12;

	localparam int AW = evar_pkg::ADDR_BITS;
	localparam int PW = evar_pkg::PIXEL_BITS;
	localparam int NW = evar_pkg::NUM_W;
	localparam int DW = evar_pkg::DIV_W;
	localparam int RW = evar_pkg::REM_W;

	logic [PW-1:0] mem [evar_pkg::MAX_PIXELS];

	logic [3:0]    state_q;
	logic [AW-1:0] sweep_q;
	logic [AW-1:0] idx_q;
	logic          pol_q;
	logic [PW-1:0] rd_q;
	logic [31:0]   ev_q;
	logic [39:0]   s1_q;
	logic [55:0]   s2_q;
	logic [PW-1:0] peak_q;
	logic [25:0]   n_q;
	logic [51:0]   d_q;
	logic          zero_q;
	logic [NW-1:0] mcand_q;
	logic [31:0]   mplier_q;
	logic [NW-1:0] acc_q;
	logic          sub_q;
	logic [4:0]    cnt_q;
	logic [DW-1:0] div_q;
	logic [RW-1:0] rem_q;
	logic [6:0]    dcnt_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [PW-1:0] wdata;
	logic [PW:0]   sum_pix;
	logic [PW-1:0] nv;
	logic          dv;
	logic [56:0]   s2_sum;
	logic [NW-1:0] acc_nxt;
	logic [RW-1:0] rem_sh;
	logic          qbit;
	logic          out_free;
	logic          out_load;

	always_comb begin
		sum_pix = {1'b0, rd_q} + (PW+1)'(pol_q);
		nv      = sum_pix[PW] ? {PW{1'b1}} : sum_pix[PW-1:0];
		dv      = (nv != rd_q);
		s2_sum  = {1'b0, s2_q} + 57'({rd_q, 1'b1});
		acc_nxt = acc_q;
		if (mplier_q[0]) acc_nxt = sub_q ? acc_q - mcand_q : acc_q + mcand_q;
		rem_sh = {rem_q[RW-2:0], div_q[DW-1]};
		qbit   = (rem_sh >= {1'b0, d_q});
		out_free = !out_valid || !out_stall;
		out_load = (state_q == ST_OUT) && out_free;
		we    = 1'b0;
		waddr = idx_q;
		wdata = nv;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				we    = 1'b1;
				waddr = sweep_q;
				wdata = '0;
			end
			ST_UPD: we = 1'b1;
			default: we = 1'b0;
		endcase
		ctl.init = (state_q == ST_INIT);
		ctl.pop  = (state_q == ST_IDLE) && !empty;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			sweep_q   <= '0;
			ev_q      <= '0;
			s1_q      <= '0;
			s2_q      <= '0;
			peak_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_INIT, ST_CLEAR: begin
					sweep_q <= sweep_q + AW'(1);
					if (&sweep_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (!empty) begin
						idx_q <= head.idx;
						pol_q <= head.pol;
						if (head.op == evar_pkg::CMD_CLEAR) begin
							sweep_q <= '0;
							ev_q    <= '0;
							s1_q    <= '0;
							s2_q    <= '0;
							peak_q  <= '0;
							state_q <= ST_CLEAR;
						end else if (head.op == evar_pkg::CMD_ADD) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_FN;
						end
					end
				end
				ST_READ: state_q <= ST_UPD;
				ST_UPD: begin
					if (!(&ev_q)) ev_q <= ev_q + 32'd1;
					if (dv) begin
						if (!(&s1_q)) s1_q <= s1_q + 40'd1;
						s2_q <= s2_sum[56] ? {56{1'b1}} : s2_sum[55:0];
					end
					if (nv > peak_q) peak_q <= nv;
					state_q <= ST_IDLE;
				end
				ST_FN: begin
					n_q     <= 26'(cfg.width) * 26'(cfg.height);
					state_q <= ST_FD;
				end
				ST_FD: begin
					d_q      <= 52'(n_q) * 52'(n_q);
					zero_q   <= (ev_q == 32'd0) || (n_q == 26'd0);
					mcand_q  <= NW'(s2_q);
					mplier_q <= 32'(n_q);
					acc_q    <= '0;
					sub_q    <= 1'b0;
					cnt_q    <= '0;
					state_q  <= ST_M1;
				end
				ST_M1, ST_M2, ST_M3: begin
					acc_q <= acc_nxt;
					cnt_q <= cnt_q + 5'd1;
					if (&cnt_q) begin
						if (state_q == ST_M1) begin
							mcand_q  <= NW'(ev_q);
							mplier_q <= ev_q;
							state_q  <= ST_M2;
						end else if (state_q == ST_M2) begin
							mcand_q  <= NW'({s1_q, 1'b0});
							mplier_q <= ev_q;
							sub_q    <= 1'b1;
							state_q  <= ST_M3;
						end else begin
							state_q <= ST_DSET;
						end
					end else begin
						mcand_q  <= {mcand_q[NW-2:0], 1'b0};
						mplier_q <= {1'b0, mplier_q[31:1]};
					end
				end
				ST_DSET: begin
					if (acc_q[NW-1]) zero_q <= 1'b1;
					div_q   <= {acc_q[DW-17:0], 16'd0};
					rem_q   <= '0;
					dcnt_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= qbit ? rem_sh - {1'b0, d_q} : rem_sh;
					div_q  <= {div_q[DW-2:0], qbit};
					dcnt_q <= dcnt_q + 7'd1;
					if (dcnt_q == 7'(DW-1)) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (zero_q) out_item.variance_q16 <= '0;
			else if (|div_q[DW-1:48]) out_item.variance_q16 <= {48{1'b1}};
			else out_item.variance_q16 <= div_q[47:0];
			out_item.max_count   <= peak_q;
			out_item.event_total <= ev_q;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/event_image_variance_core.sv =====
// An event passes through the back end as a pop, a memory read into a register
// and a write with the sum update; no further item is popped until that update
// is done, and the queue holds up to two waiting items. A clear takes its pop and
// then sweeps the whole pixel memory, one pixel a cycle; the same sweep runs once
// after reset, and no item is accepted until it ends. A finish takes a pop, setup
// of the pixel count and then of the divisor and multiplier, three 32-step
// shift-add multiplications for the numerator, a divider setup, a 100-step
// restoring division and an output state that waits out any output stall. Events
// outside the image and unknown commands are dropped at the input.
// ----------------------------------------------------------------------------
// Event image variance core
// Accumulates events into a count image and reports its variance in Q32.16.
// ----------------------------------------------------------------------------
`default_nettype none
module event_image_variance_core (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire  evar_pkg::in_item_t  in_item,
	output logic                      out_valid,
	input  wire                       out_stall,
	output evar_pkg::out_item_t       out_item,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire                       cfg_index,
	input  wire  [12:0]               cfg_data
);
	evar_pkg::cfg_t       cfg_q;
	evar_pkg::front_ctl_t fctl;
	evar_pkg::back_ctl_t  bctl;
	evar_pkg::op_t        push_op;
	evar_pkg::op_t        head;
	logic                 empty;
	logic                 full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= 13'd1280;
			cfg_q.height <= 13'd720;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == evar_pkg::CFG_WIDTH) cfg_q.width <= cfg_data;
			else cfg_q.height <= cfg_data;
		end
	end

	evar_front u_front (
		.in_item  (in_item),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cfg      (cfg_q),
		.init     (bctl.init),
		.full     (full),
		.ctl      (fctl),
		.op       (push_op)
	);

	evar_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fctl.push),
		.push_op (push_op),
		.pop     (bctl.pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	evar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.empty     (empty),
		.ctl       (bctl),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);
endmodule
`default_nettype wire

// ===== hw/rtl/evar_checker.sv =====
// ----------------------------------------------------------------------------
// Event image variance checker
// Port-level assertions for the event image variance core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "event_image_variance_core_macros.svh"
module evar_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      out_valid,
	input wire                      out_stall,
	input wire evar_pkg::out_item_t out_item,
	input wire                      cfg_ready
);
	`EVAR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`EVAR_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_item))
	`EVAR_ASSERT_NOW(a_no_events_zero, out_valid && (out_item.event_total == 32'd0), out_item.variance_q16 == 48'd0)
	`EVAR_ASSERT_NOW(a_peak_needs_events, out_valid && (out_item.max_count != 16'd0), out_item.event_total != 32'd0)
	`EVAR_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)
endmodule

bind event_image_variance_core evar_checker u_evar_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item),
	.cfg_ready (cfg_ready)
);
`default_nettype wire
